[src/binco_pkg.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient package
// Widths, the shared stage control type and the per-step divisor constants.
// ----------------------------------------------------------------------------
package binco_pkg;

  localparam int unsigned MaxN       = 31;
  localparam int unsigned NWidth     = 5;
  localparam int unsigned RWidth     = 5;
  localparam int unsigned ValueWidth = 29;
  // Folded r never exceeds 15, so 15 multiply/divide steps.
  localparam int unsigned NumSteps   = MaxN / 2;
  localparam int unsigned KWidth     = 4;

  typedef logic [NWidth-1:0]     n_t;
  typedef logic [KWidth-1:0]     k_t;
  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [1:0]            shift_t;

  typedef struct packed {
    logic   valid;
    n_t     n;
    k_t     r;
    value_t res;
  } stage_t;

  // Count trailing zeros of a step divisor.
  function automatic shift_t k_shift(int unsigned k);
    shift_t      s;
    int unsigned v;
    s = '0;
    v = k;
    for (int i = 0; i < 3; i++) begin
      if (v != 0 && v[0] == 1'b0) begin
        v = v >> 1;
        s = s + 1'b1;
      end
    end
    return s;
  endfunction

  // Inverse of the odd part of a step divisor, modulo 2^ValueWidth.
  function automatic value_t k_inverse(int unsigned k);
    value_t o;
    value_t x;
    o = value_t'(k >> k_shift(k));
    x = o;
    for (int i = 0; i < 4; i++) begin
      x = x * (value_t'(2) - o * x);
    end
    return x;
  endfunction

endpackage

[src/binomial_coefficient.sv]
// Depth: 1 + 2*15 = 31 register stages from the input to the result.
// Throughput: one item per cycle while the output is taken; a 15-step
// chain of multiply and constant-divide stages, each step two registers
// deep.
// The whole pipeline stalls together when the output is not taken.
// Reset clears all pipeline registers.
// ----------------------------------------------------------------------------
// Binomial coefficient
// Pipelined C(n, r) with r folded to the smaller half.
// ----------------------------------------------------------------------------
module binomial_coefficient import binco_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  n_t     n_i,
  input  n_t     r_i,
  output logic   valid_o,
  input  logic   ready_i,
  output value_t value_o
);

  stage_t chain [NumSteps+1];
  logic   en;

  assign en      = ready_i || !chain[NumSteps].valid;
  assign ready_o = en;

  binco_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i, .n_i, .r_i, .stage_o(chain[0])
  );

  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    binco_step u_step (
      .clk_i, .rst_ni, .en_i(en),
      .k_i(k_t'(g + 1)), .shift_i(k_shift(g + 1)), .inv_i(k_inverse(g + 1)),
      .stage_i(chain[g]), .stage_o(chain[g+1])
    );
  end

  assign valid_o = chain[NumSteps].valid;
  assign value_o = (chain[NumSteps].n > n_t'(MaxN)) ? '0 : chain[NumSteps].res;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(value_o))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o)
    else $error("not ready while output empty");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && chain[NumSteps].r == '0 && chain[NumSteps].n <= n_t'(MaxN)
      |-> value_o <= value_t'(1))
    else $error("r of zero gave more than one");
`endif

endmodule

[src/binco_prep.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient input stage
// Folds r to n - r when r is above n/2, and flags r above n.
// ----------------------------------------------------------------------------
module binco_prep import binco_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  n_t     n_i,
  input  n_t     r_i,
  output stage_t stage_o
);

  stage_t stage_d, stage_q;
  n_t     rf;

  always_comb begin
    stage_d       = '0;
    stage_d.valid = valid_i;
    stage_d.n     = n_i;
    rf            = (r_i > (n_i >> 1)) ? n_i - r_i : r_i;
    stage_d.r     = rf[KWidth-1:0];
    stage_d.res   = (r_i > n_i) ? '0 : value_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

[src/binco_step.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient step
// Two registers: res*(n-k+1), then exact divide by k as a shift and a
// multiply by the inverse of the odd part of k; inactive steps pass res.
// ----------------------------------------------------------------------------
module binco_step import binco_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  k_t     k_i,
  input  shift_t shift_i,
  input  value_t inv_i,
  input  stage_t stage_i,
  output stage_t stage_o
);

  stage_t            mid_q, out_q, out_d;
  logic              act_q;
  logic [33:0]       prod_q;
  logic [NWidth:0]   fac;
  logic              act;

  assign act = (stage_i.n <= n_t'(MaxN)) && (stage_i.r >= k_i);
  assign fac = {1'b0, stage_i.n} - {2'b00, k_i} + (NWidth+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= '0;
      out_q  <= '0;
      act_q  <= 1'b0;
      prod_q <= '0;
    end else if (en_i) begin
      mid_q  <= stage_i;
      act_q  <= act;
      prod_q <= 34'(stage_i.res) * 34'(fac);
      out_q  <= out_d;
    end
  end

  always_comb begin
    out_d = mid_q;
    if (act_q) begin
      out_d.res = value_t'(prod_q >> shift_i) * inv_i;
    end
  end

  assign stage_o = out_q;

endmodule

[tb/sv/binomial_coefficient_tb.sv]
// ----------------------------------------------------------------------------
// Binomial coefficient testbench
// Drives (n, r) pairs through the valid/ready input channel, predicts
// C(n, r) for each accepted item and compares every result in order.
// Starts with directed corner pairs, then random pairs with random idling.
// ----------------------------------------------------------------------------
module binomial_coefficient_tb;
  import binco_pkg::*;

  localparam int unsigned NumRandom = 1530;
  localparam int unsigned Latency   = 32;

  typedef struct {
    n_t     n;
    n_t     r;
    logic   has_value;
    value_t value;
  } row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   valid_i;
  logic   ready_o;
  n_t     n_i;
  n_t     r_i;
  logic   valid_o;
  logic   ready_i;
  value_t value_o;

  value_t value_q[$];
  int     errors;
  int     num_sent;
  int     num_checked;
  logic   calm;
  row_t   rows[$];

  binomial_coefficient dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .n_i    (n_i),
    .r_i    (r_i),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .value_o(value_o)
  );

  function automatic value_t choose_value(n_t n, n_t r);
    longint unsigned acc;
    int unsigned     kk;
    int unsigned     rr;
    acc = 1;
    rr  = r;
    if (n > MaxN || r > n) begin
      return '0;
    end
    if (rr > n / 2) begin
      rr = n - rr;
    end
    for (kk = 1; kk <= rr; kk++) begin
      acc = acc * (n - kk + 1) / kk;
    end
    return value_t'(acc);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // Sink: random stall bursts, none once calm.
  initial begin
    int gap;
    ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      if (value_q.size() == 0) begin
        $error("unexpected result value=%0d", value_o);
        errors++;
      end else begin
        if (value_o !== value_q[0]) begin
          $error("value: expected %0d, actual %0d", value_q[0], value_o);
          errors++;
        end
        void'(value_q.pop_front());
        num_checked++;
      end
    end
  end

  task automatic send_item(n_t n, n_t r, value_t exp_value);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    n_i     <= n;
    r_i     <= r;
    value_q.push_back(exp_value);
    do @(posedge clk_i); while (!ready_o);
    num_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    value_t exp_value;
    n_t     n;
    n_t     r;
    int     wait_cycles;
    errors      = 0;
    num_sent    = 0;
    num_checked = 0;
    calm        = 1'b0;
    valid_i     = 1'b0;
    n_i         = '0;
    r_i         = '0;
    rst_ni      = 1'b0;
    // value typed in where obvious; others predicted
    rows = '{
      '{5'd0,  5'd0,  1'b1, 29'd1},
      '{5'd31, 5'd0,  1'b1, 29'd1},
      '{5'd31, 5'd31, 1'b1, 29'd1},
      '{5'd0,  5'd31, 1'b1, 29'd0},
      '{5'd30, 5'd31, 1'b1, 29'd0},
      '{5'd1,  5'd2,  1'b1, 29'd0},
      '{5'd1,  5'd1,  1'b1, 29'd1},
      '{5'd31, 5'd1,  1'b1, 29'd31},
      '{5'd31, 5'd30, 1'b1, 29'd31},
      '{5'd31, 5'd15, 1'b1, 29'd300540195},
      '{5'd31, 5'd16, 1'b1, 29'd300540195},
      '{5'd30, 5'd15, 1'b0, 29'd0},
      '{5'd30, 5'd16, 1'b0, 29'd0},
      '{5'd2,  5'd1,  1'b0, 29'd0},
      '{5'd10, 5'd3,  1'b0, 29'd0},
      '{5'd21, 5'd10, 1'b0, 29'd0},
      '{5'd16, 5'd8,  1'b0, 29'd0},
      '{5'd15, 5'd7,  1'b0, 29'd0},
      '{5'd29, 5'd14, 1'b0, 29'd0},
      '{5'd31, 5'd17, 1'b0, 29'd0}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) begin
      exp_value = rows[i].has_value ? rows[i].value : choose_value(rows[i].n, rows[i].r);
      send_item(rows[i].n, rows[i].r, exp_value);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 200) begin
        calm = 1'b1;
      end
      n = n_t'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        r = n_t'($urandom);
      end else begin
        r = n_t'($urandom_range(0, n));
      end
      send_item(n, r, choose_value(n, r));
    end
    valid_i <= 1'b0;
    wait_cycles = 0;
    while (value_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * Latency) @(posedge clk_i);
    $display("Sent %0d (n, r) pairs, checked %0d coefficients.", num_sent, num_checked);
    if (errors == 0 && value_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
src/binco_pkg.sv
src/binco_prep.sv
src/binco_step.sv
src/binomial_coefficient.sv
tb/sv/binomial_coefficient_tb.sv
